// ===== hw/rtl/kwmms_pkg.sv =====
// Shared constants and types for the k-way run merge selector.
package kwmms_pkg;

  localparam int NUM_REGIONS = 16;
  localparam int KEY_BITS    = 32;
  localparam int RUN_W       = $clog2(NUM_REGIONS);
  localparam int CNT_W       = RUN_W + 1;
  localparam int CFG_W       = 5;
  localparam int MODE_W      = 2;
  localparam int IN_RUN_W    = 4;
  localparam int IN_KEY_W    = 32;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PULL = 2'd2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [RUN_W-1:0]    run_t;

  typedef struct packed {
    logic wr_en;
    run_t wr_addr;
    key_t wr_key;
    logic clr_en;
    run_t clr_addr;
  } store_cmd_t;

  typedef struct packed {
    logic clr;
    logic smp;
    run_t idx;
  } scan_cmd_t;

  typedef struct packed {
    logic found;
    run_t best_run;
    key_t best_key;
  } scan_res_t;

endpackage

// ===== hw/rtl/kway_run_merge_min_select_top.sv =====
// Top level of the k-way run merge selector: handshakes, sequencer, output register.
//
// Input beats arrive on in_tvalid/in_tready. in_tuser carries the mode (load,
// end, pull) and in_tdata the run index and head key. A load or end beat
// updates the run's head key and valid mark; it gives no result. A pull beat
// starts a scan of every run head through one shared comparator, one head per
// cycle, which compares only valid heads below the active run count. The scan
// goes through the single memory read port, visiting the comparator once per run.
// in_tready is low from acceptance of a pull until its result is loaded, so no
// new beat is taken while a pull is in progress.
// Each pull gives one result beat on out_tvalid/out_tready: out_tdata holds the
// chosen run and key, out_tuser the done flag. The result sits in an output
// register, so load and end beats keep flowing while it waits; a following
// pull waits at its end until the previous result has been taken.
// cfg_valid/cfg_data write the active run count, always accepted; the user must
// write it only while the block is idle; the block itself does not enforce this. Reset clears all valid marks, sets
// the active run count to 16 and drops out_tvalid.
module kway_run_merge_min_select_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kwmms_pkg::IN_DATA_W-1:0]  in_tdata,   // run_index, head_key, zero pad
  input  logic [kwmms_pkg::MODE_W-1:0]     in_tuser,   // mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kwmms_pkg::OUT_DATA_W-1:0] out_tdata,  // chosen_run, chosen_key, zero pad
  output logic [0:0]                       out_tuser,  // merge_done
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kwmms_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  kwmms_pkg::run_t                idx_r, idx_nxt;
  logic                           stg_en_r;
  logic                           stg_in_r;
  kwmms_pkg::run_t                stg_idx_r;
  logic [kwmms_pkg::CFG_W-1:0]    active_r;
  logic [kwmms_pkg::CNT_W-1:0]    limit;
  logic                           out_vld_r;
  kwmms_pkg::run_t                out_run_r;
  kwmms_pkg::key_t                out_key_r;
  logic                           out_done_r;

  logic                           in_acc;
  logic [kwmms_pkg::MODE_W-1:0]   in_mode;
  logic [kwmms_pkg::IN_RUN_W-1:0] in_run;
  logic [kwmms_pkg::IN_KEY_W-1:0] in_key;
  logic                           in_run_ok;
  logic                           fin_go;

  kwmms_pkg::store_cmd_t          st_cmd;
  kwmms_pkg::key_t                rd_key;
  logic                           rd_vld;
  kwmms_pkg::scan_cmd_t           sc_cmd;
  kwmms_pkg::scan_res_t           sc_res;

  assign in_mode   = in_tuser;
  assign in_run    = in_tdata[kwmms_pkg::IN_RUN_W-1:0];
  assign in_key    = in_tdata[kwmms_pkg::IN_RUN_W +: kwmms_pkg::IN_KEY_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_run_ok = (32'(in_run) < kwmms_pkg::NUM_REGIONS);
  assign cfg_ready = 1'b1;

  // Counts above the number of runs scan every run.
  assign limit = (32'(active_r) > kwmms_pkg::NUM_REGIONS) ?
                 kwmms_pkg::CNT_W'(kwmms_pkg::NUM_REGIONS) :
                 kwmms_pkg::CNT_W'(active_r);

  assign fin_go = (state_r == S_FIN) && (!out_vld_r || out_tready);

  always_comb begin
    st_cmd.wr_en    = in_acc && (in_mode == kwmms_pkg::MODE_LOAD) && in_run_ok;
    st_cmd.wr_addr  = kwmms_pkg::RUN_W'(in_run);
    st_cmd.wr_key   = kwmms_pkg::KEY_BITS'(in_key);
    st_cmd.clr_en   = (in_acc && (in_mode == kwmms_pkg::MODE_END) && in_run_ok) ||
                      (fin_go && sc_res.found);
    st_cmd.clr_addr = (state_r == S_FIN) ? sc_res.best_run : kwmms_pkg::RUN_W'(in_run);
  end

  always_comb begin
    sc_cmd.clr = in_acc && (in_mode == kwmms_pkg::MODE_PULL);
    sc_cmd.smp = stg_en_r && stg_in_r && rd_vld;
    sc_cmd.idx = stg_idx_r;
  end

  kwmms_head_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (st_cmd),
    .rd_addr (idx_r),
    .rd_key  (rd_key),
    .rd_vld  (rd_vld)
  );

  kwmms_min_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (sc_cmd),
    .key   (rd_key),
    .res   (sc_res)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == kwmms_pkg::MODE_PULL)) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (32'(idx_r) == kwmms_pkg::NUM_REGIONS - 1) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      stg_en_r  <= 1'b0;
      active_r  <= kwmms_pkg::ACTIVE_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      stg_en_r <= (state_r == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      if (fin_go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Index and range flag travel alongside the registered memory read.
  always_ff @(posedge clk) begin
    stg_idx_r <= idx_r;
    stg_in_r  <= ({1'b0, idx_r} < limit);
    if (fin_go) begin
      out_done_r <= !sc_res.found;
      out_run_r  <= sc_res.found ? sc_res.best_run : '0;
      out_key_r  <= sc_res.found ? sc_res.best_key : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(kwmms_pkg::OUT_DATA_W - kwmms_pkg::RUN_W - kwmms_pkg::KEY_BITS)'(0),
                       out_key_r, out_run_r};
  assign out_tuser  = out_done_r;

  a_pull_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == kwmms_pkg::MODE_PULL)) |=> (state_r == S_SCAN) && (idx_r == '0))
    else $error("pull did not start a scan at run zero");

  a_stage_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    stg_en_r |-> $past(state_r == S_SCAN))
    else $error("sample stage active outside a scan");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_vld_r && (!out_done_r || ((out_run_r == '0) && (out_key_r == '0))))
    else $error("result not loaded, or done result not zero");

  a_no_sample_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sc_cmd.smp)
    else $error("comparator sampled while idle");

endmodule

// ===== hw/rtl/kwmms_head_store.sv =====
// Head key memory and per-run valid bits, with one registered read port.
module kwmms_head_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kwmms_pkg::store_cmd_t cmd,
  input  kwmms_pkg::run_t      rd_addr,
  output kwmms_pkg::key_t      rd_key,
  output logic                 rd_vld
);

  kwmms_pkg::key_t                 mem [kwmms_pkg::NUM_REGIONS];
  logic [kwmms_pkg::NUM_REGIONS-1:0] vld_r;
  kwmms_pkg::key_t                 rd_key_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_key;
    end
    rd_key_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.clr_en) begin
        vld_r[cmd.clr_addr] <= 1'b0;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_vld = rd_vld_r;

endmodule

// ===== hw/rtl/kwmms_min_scan.sv =====
// Shared comparator that keeps the smallest sampled head and its run index.
module kwmms_min_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kwmms_pkg::scan_cmd_t  cmd,
  input  kwmms_pkg::key_t       key,
  output kwmms_pkg::scan_res_t  res
);

  logic            found_r;
  kwmms_pkg::run_t best_run_r;
  kwmms_pkg::key_t best_key_r;
  logic            take;

  // Strict less-than keeps the lowest index on equal keys, since runs are
  // visited in ascending order.
  assign take = cmd.smp && (!found_r || (key < best_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !cmd.clr) begin
      best_run_r <= cmd.idx;
      best_key_r <= key;
    end
  end

  assign res.found    = found_r;
  assign res.best_run = best_run_r;
  assign res.best_key = best_key_r;

endmodule

// ===== sim/kwmms_checker.sv =====
// Checker for the k-way run merge selector: tracks run heads, predicts each pull, compares beats.
module kwmms_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [kwmms_pkg::IN_DATA_W-1:0]  in_tdata,   // run_index, head_key, zero pad
  input  logic [kwmms_pkg::MODE_W-1:0]     in_tuser,   // mode
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [kwmms_pkg::OUT_DATA_W-1:0] out_tdata,  // chosen_run, chosen_key, zero pad
  input  logic [0:0]                       out_tuser,  // merge_done
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [kwmms_pkg::CFG_W-1:0]      cfg_data,
  output int                               fail_count,
  output int                               picks_pending
);
  import kwmms_pkg::*;

  typedef struct packed {
    run_t run;
    key_t key;
    logic done;
  } pick_t;

  pick_t            picks_due[$];
  key_t             head_key[NUM_REGIONS];
  logic             head_valid[NUM_REGIONS];
  logic [CFG_W-1:0] active_runs;
  int               fails = 0;

  assign fail_count = fails;

  task automatic report(input string field, input pick_t got, input pick_t want);
    $display("%0t kwmms_checker: %s mismatch: got %0d/%h/%0b, want %0d/%h/%0b",
             $realtime, field, got.run, got.key, got.done, want.run, want.key, want.done);
    fails++;
  endtask

  // Smallest valid head among the scanned runs; the lowest index wins a tie.
  function automatic pick_t pick_smallest();
    pick_t p;
    int    limit;
    p = '{run: '0, key: '0, done: 1'b1};
    limit = (active_runs > NUM_REGIONS) ? NUM_REGIONS : int'(active_runs);
    for (int i = 0; i < limit; i++) begin
      if (head_valid[i] && (p.done || head_key[i] < p.key)) begin
        p.run  = run_t'(i);
        p.key  = head_key[i];
        p.done = 1'b0;
      end
    end
    if (!p.done) head_valid[p.run] = 1'b0;
    return p;
  endfunction

  always @(posedge clk) begin : watch
    pick_t got;
    pick_t want;
    run_t  run;
    key_t  key;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGIONS; i++) head_valid[i] = 1'b0;
      active_runs = ACTIVE_RESET;
      picks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) active_runs = cfg_data;
      if (out_tvalid && out_tready) begin
        got.run  = out_tdata[RUN_W-1:0];
        got.key  = out_tdata[RUN_W +: KEY_BITS];
        got.done = out_tuser[0];
        if (picks_due.size() == 0) begin
          report("unexpected result beat", got, got);
        end else begin
          want = picks_due.pop_front();
          if (got.run !== want.run) report("chosen_run", got, want);
          if (got.key !== want.key) report("chosen_key", got, want);
          if (got.done !== want.done) report("merge_done", got, want);
        end
      end
      if (in_tvalid && in_tready) begin
        run = in_tdata[IN_RUN_W-1:0];
        key = in_tdata[IN_RUN_W +: IN_KEY_W];
        case (in_tuser)
          MODE_LOAD: begin
            head_key[run]   = key;
            head_valid[run] = 1'b1;
          end
          MODE_END: head_valid[run] = 1'b0;
          MODE_PULL: picks_due.push_back(pick_smallest());
          default: ;
        endcase
      end
    end
    picks_pending <= picks_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the k-way run merge selector: clock, reset, stimulus and verdict.
module tb_top;
  import kwmms_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int DRAIN_CYCLES  = 32;
  localparam int HOLD_CYCLES   = 200;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SEGMENT_ITEMS = 85;
  localparam int NUM_SEGMENTS  = 6;
  // The one mode code that the block ignores.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // run_index, head_key, zero pad
  logic [MODE_W-1:0]     in_tuser   = '0;   // mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // chosen_run, chosen_key, zero pad
  logic [0:0]            out_tuser;         // merge_done
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data   = '0;

  int fail_count;
  int picks_pending;
  int tx_idle_pct  = 30;
  int rx_idle_pct  = 68;
  int holds_asked  = 0;
  int holds_given  = 0;
  logic [CFG_W-1:0] segment_runs[NUM_SEGMENTS];

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  kway_run_merge_min_select_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  kwmms_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .picks_pending (picks_pending)
  );

  // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_given) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_given++;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input run_t run, input key_t key);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_DATA_W - IN_RUN_W - IN_KEY_W){1'b0}}, key, run};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly loads and pulls; small keys make ties between runs common.
  task automatic send_random_item(output bit counted);
    int                pick;
    logic [MODE_W-1:0] mode;
    key_t              key;
    pick = $urandom_range(99);
    if (pick < 45)      mode = MODE_LOAD;
    else if (pick < 55) mode = MODE_END;
    else if (pick < 95) mode = MODE_PULL;
    else                mode = MODE_SPARE;
    key = $urandom_range(1) ? key_t'($urandom) : key_t'($urandom_range(15));
    send_item(mode, run_t'($urandom_range(NUM_REGIONS - 1)), key);
    counted = (mode != MODE_SPARE);
  endtask

  // Waits until every pull has been answered and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (picks_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_runs(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    bit counted;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset run count.
    send_item(MODE_PULL, 4'd0, '0);               // nothing loaded yet
    send_item(MODE_LOAD, 4'd0, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 4'd15, 32'h0000_0000);
    send_item(MODE_PULL, 4'd9, 32'h1234_5678);
    send_item(MODE_PULL, 4'd0, '0);
    send_item(MODE_PULL, 4'd0, '0);               // all heads taken again
    send_item(MODE_LOAD, 4'd3, 32'd5);
    send_item(MODE_LOAD, 4'd7, 32'd5);
    send_item(MODE_PULL, 4'd0, '0);               // tie goes to the lower run
    send_item(MODE_LOAD, 4'd7, 32'd1);            // overwrites a head that is still valid
    send_item(MODE_LOAD, 4'd12, 32'd2);
    send_item(MODE_PULL, 4'd0, '0);
    send_item(MODE_END, 4'd12, 32'hDEAD_BEEF);
    send_item(MODE_SPARE, 4'd12, 32'hAAAA_5555);
    send_item(MODE_PULL, 4'd0, '0);
    send_item(MODE_LOAD, 4'd10, 32'h8000_0000);
    send_item(MODE_LOAD, 4'd5, 32'h7FFF_FFFF);
    send_item(MODE_PULL, 4'd0, '0);
    send_item(MODE_PULL, 4'd15, 32'hFFFF_FFFF);
    send_item(MODE_PULL, 4'd0, '0);
    settle();

    // Run counts per segment: one run, none, above the region count, and ordinary values.
    segment_runs[0] = 5'd1;
    segment_runs[1] = 5'd0;
    segment_runs[2] = 5'd31;
    segment_runs[3] = 5'd9;
    segment_runs[4] = CFG_W'($urandom_range(2, NUM_REGIONS - 1));
    segment_runs[5] = 5'd16;

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg < 2) begin
        tx_idle_pct = 30;
        rx_idle_pct <= 68;
      end else if (seg < 4) begin
        tx_idle_pct = 68;
        rx_idle_pct <= 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      write_active_runs(segment_runs[seg]);
      // The receiver holds off while beats keep coming, so the block backs up.
      if (seg == 4) holds_asked <= holds_asked + 1;
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        send_random_item(counted);
        sent += counted;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kwmms_pkg.sv
hw/rtl/kwmms_head_store.sv
hw/rtl/kwmms_min_scan.sv
hw/rtl/kway_run_merge_min_select_top.sv
sim/kwmms_checker.sv
sim/tb_top.sv
